// ===== hdl/lcd_seq_pkg.sv =====
// Package for the character LCD nibble write sequencer.
// Holds the phase and request codes, display command constants and the init table.
// No dependencies.
package lcd_seq_pkg;

	// Sequencer phases.
	typedef enum logic [2:0] {
		PH_POWER = 3'd0,
		PH_UPPER = 3'd1,
		PH_GAP   = 3'd2,
		PH_LOWER = 3'd3,
		PH_WAIT  = 3'd4,
		PH_EXTRA = 3'd5,
		PH_IDLE  = 3'd6
	} phase_t;

	// Request codes carried in the func field.
	typedef enum logic [2:0] {
		FN_TICK  = 3'd0,
		FN_CMD   = 3'd1,
		FN_CHAR  = 3'd2,
		FN_POS   = 3'd3,
		FN_CLEAR = 3'd4
	} func_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_PULSE = 2'd0,
		REG_GAP   = 2'd1,
		REG_WAIT  = 2'd2,
		REG_POWER = 2'd3
	} cfg_reg_t;

	localparam int unsigned TICK_W = 20;
	localparam int unsigned INIT_COUNT = 5;

	// Reset values of the timing registers.
	localparam logic [TICK_W-1:0] PULSE_RST = 20'd1;
	localparam logic [TICK_W-1:0] GAP_RST   = 20'd200;
	localparam logic [TICK_W-1:0] WAIT_RST  = 20'd2000;
	localparam logic [TICK_W-1:0] POWER_RST = 20'd20000;

	// Display commands.
	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] CMD_ROW0   = 8'h80;
	localparam logic [7:0] CMD_ROW1   = 8'hC0;
	localparam logic [7:0] COL_MASK   = 8'h3F;

	// Init sequence: return home, 4-bit two-line mode, display on, entry mode, clear.
	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h02;
			3'd1:    b = 8'h28;
			3'd2:    b = 8'h0C;
			3'd3:    b = 8'h06;
			3'd4:    b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== hdl/char_lcd_nibble_write_sequencer.sv =====
// Top level of the character LCD nibble write sequencer (4-bit display interface).
// Each tick's result is registered; one tick accepted per cycle while not stalled.
// A tick enters in the cycle the held result is taken; a stalled result blocks the input.
// Reset (arst_n low): power-on wait phase, counters cleared, timing registers at defaults.
// Depends on lcd_seq_pkg.
module char_lcd_nibble_write_sequencer #(
	parameter int COLUMNS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_wdata,
	// Tick input: func [2:0], byte_value [10:3], row [18:11], column [26:19].
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	// Result: data_nibble [3:0], register_select [4], enable_line [5],
	// busy_res [6], rejected [7].
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata
);

	localparam logic [7:0] COLS_LIM = 8'(COLUMNS);
	localparam int unsigned TW = lcd_seq_pkg::TICK_W;

	// Timing registers.
	logic [TW-1:0] pulse_q, gap_q, wait_q, power_q;

	// Sequencer state.
	lcd_seq_pkg::phase_t phase_q, phase_n;
	logic [TW-1:0] cnt_q, cnt_n;
	logic [7:0]    byte_q, byte_n;
	logic          rs_q, rs_n;
	logic [2:0]    idx_q, idx_n;
	logic          home_q, home_n;

	// Result register.
	logic          m_tvalid_q;
	logic [7:0]    m_tdata_q;

	logic          s_accept;
	logic [2:0]    in_func;
	logic [7:0]    in_byte, in_row, in_col;
	logic [7:0]    res;

	assign in_func = s_axis_tdata[2:0];
	assign in_byte = s_axis_tdata[10:3];
	assign in_row  = s_axis_tdata[18:11];
	assign in_col  = s_axis_tdata[26:19];

	assign s_axis_tready = !m_tvalid_q || m_axis_tready;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= lcd_seq_pkg::PULSE_RST;
			gap_q   <= lcd_seq_pkg::GAP_RST;
			wait_q  <= lcd_seq_pkg::WAIT_RST;
			power_q <= lcd_seq_pkg::POWER_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lcd_seq_pkg::REG_PULSE: pulse_q <= cfg_wdata;
				lcd_seq_pkg::REG_GAP:   gap_q   <= cfg_wdata;
				lcd_seq_pkg::REG_WAIT:  wait_q  <= cfg_wdata;
				lcd_seq_pkg::REG_POWER: power_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// One tick: take the request, form the line levels, then advance the phase timer.
	always_comb begin
		logic          rej;
		logic [3:0]    nib;
		logic          en;
		logic          busy;
		logic [TW-1:0] len;
		logic [TW-1:0] len_eff;

		phase_n = phase_q;
		cnt_n   = cnt_q;
		byte_n  = byte_q;
		rs_n    = rs_q;
		idx_n   = idx_q;
		home_n  = home_q;
		rej     = 1'b0;

		// Requests start now when idle, bad positions dropped; otherwise rejected.
		if (in_func inside {lcd_seq_pkg::FN_CMD, lcd_seq_pkg::FN_CHAR,
				lcd_seq_pkg::FN_POS, lcd_seq_pkg::FN_CLEAR}) begin
			if (phase_q != lcd_seq_pkg::PH_IDLE) begin
				rej = 1'b1;
			end else begin
				case (in_func)
					lcd_seq_pkg::FN_CMD: begin
						byte_n = in_byte; rs_n = 1'b0;
						phase_n = lcd_seq_pkg::PH_UPPER; cnt_n = '0;
					end
					lcd_seq_pkg::FN_CHAR: begin
						byte_n = in_byte; rs_n = 1'b1;
						phase_n = lcd_seq_pkg::PH_UPPER; cnt_n = '0;
					end
					lcd_seq_pkg::FN_POS: begin
						if (in_col < COLS_LIM && in_row == 8'd0) begin
							byte_n = lcd_seq_pkg::CMD_ROW0 | (in_col & lcd_seq_pkg::COL_MASK);
							rs_n = 1'b0; phase_n = lcd_seq_pkg::PH_UPPER; cnt_n = '0;
						end else if (in_col < COLS_LIM && in_row == 8'd1) begin
							byte_n = lcd_seq_pkg::CMD_ROW1 | (in_col & lcd_seq_pkg::COL_MASK);
							rs_n = 1'b0; phase_n = lcd_seq_pkg::PH_UPPER; cnt_n = '0;
						end
					end
					default: begin
						home_n = 1'b1;
						byte_n = lcd_seq_pkg::CMD_CLEAR; rs_n = 1'b0;
						phase_n = lcd_seq_pkg::PH_UPPER; cnt_n = '0;
					end
				endcase
			end
		end

		// Line levels during this tick.
		if (phase_n == lcd_seq_pkg::PH_POWER) begin
			nib = 4'h0;
		end else if (phase_n == lcd_seq_pkg::PH_UPPER || phase_n == lcd_seq_pkg::PH_GAP) begin
			nib = byte_n[7:4];
		end else begin
			nib = byte_n[3:0];
		end
		en   = (phase_n == lcd_seq_pkg::PH_UPPER || phase_n == lcd_seq_pkg::PH_LOWER);
		busy = (phase_n != lcd_seq_pkg::PH_IDLE);
		res  = {rej, busy, en, rs_n, nib};

		// Length of the current phase; a zero register counts as one tick.
		case (phase_n)
			lcd_seq_pkg::PH_POWER: len = power_q;
			lcd_seq_pkg::PH_UPPER: len = pulse_q;
			lcd_seq_pkg::PH_GAP:   len = gap_q;
			lcd_seq_pkg::PH_LOWER: len = pulse_q;
			default:               len = wait_q;
		endcase
		len_eff = (len == '0) ? TW'(1) : len;

		// Advance the timer and end the phase when it runs out.
		if (busy) begin
			cnt_n = cnt_n + TW'(1);
			if (cnt_n >= len_eff || cnt_n == '0) begin
				cnt_n = '0;
				case (phase_n)
					lcd_seq_pkg::PH_POWER: begin
						idx_n = 3'd1;
						byte_n = lcd_seq_pkg::init_byte(3'd0); rs_n = 1'b0;
						phase_n = lcd_seq_pkg::PH_UPPER;
					end
					lcd_seq_pkg::PH_UPPER: phase_n = lcd_seq_pkg::PH_GAP;
					lcd_seq_pkg::PH_GAP:   phase_n = lcd_seq_pkg::PH_LOWER;
					lcd_seq_pkg::PH_LOWER: phase_n = lcd_seq_pkg::PH_WAIT;
					lcd_seq_pkg::PH_WAIT: begin
						if (idx_n != 3'd0) begin
							if (idx_n < 3'(lcd_seq_pkg::INIT_COUNT)) begin
								byte_n = lcd_seq_pkg::init_byte(idx_n); rs_n = 1'b0;
								phase_n = lcd_seq_pkg::PH_UPPER;
								idx_n = idx_n + 3'd1;
							end else begin
								idx_n = 3'd0;
								phase_n = lcd_seq_pkg::PH_EXTRA;
							end
						end else if (home_n) begin
							phase_n = lcd_seq_pkg::PH_EXTRA;
						end else begin
							phase_n = lcd_seq_pkg::PH_IDLE;
						end
					end
					lcd_seq_pkg::PH_EXTRA: begin
						if (home_n) begin
							home_n = 1'b0;
							byte_n = lcd_seq_pkg::CMD_ROW0; rs_n = 1'b0;
							phase_n = lcd_seq_pkg::PH_UPPER;
						end else begin
							phase_n = lcd_seq_pkg::PH_IDLE;
						end
					end
					default: phase_n = lcd_seq_pkg::PH_IDLE;
				endcase
			end
		end
	end

	// State update on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lcd_seq_pkg::PH_POWER;
			cnt_q   <= '0;
			byte_q  <= '0;
			rs_q    <= 1'b0;
			idx_q   <= '0;
			home_q  <= 1'b0;
		end else if (s_accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			byte_q  <= byte_n;
			rs_q    <= rs_n;
			idx_q   <= idx_n;
			home_q  <= home_n;
		end
	end

	// Result register with its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_axis_tready) begin
			m_tvalid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			m_tdata_q <= res;
		end
	end

	// Checks that a rejected request is reported only while busy.
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[6])
		else $error("rejected flag without busy");

	// The enable strobe only rises during a busy sequence.
	a_en_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[6])
		else $error("enable strobe while idle");

	// Every accepted tick yields a result in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> m_tvalid_q)
		else $error("accepted tick produced no result");

	// The init sequence is over whenever the sequencer is idle.
	a_idle_init: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lcd_seq_pkg::PH_IDLE |-> idx_q == 3'd0 && !home_q)
		else $error("idle with init or home pending");

endmodule
